// File: rtl/gnnt_pkg.sv
// Package: payload types and constants of the nearest-neighbor tracker.
package gnnt_pkg;

   localparam int MaxTargetsDefault = 8;

   localparam logic [1:0] OP_DETECT = 2'd0;
   localparam logic [1:0] OP_FRAME  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_GATE   = 2'd0;
   localparam logic [1:0] CSR_GAIN   = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   localparam logic [14:0] GATE_RESET  = 15'd2560;
   localparam logic [8:0]  GAIN_RESET  = 9'd102;
   localparam logic [3:0]  LIMIT_RESET = 4'd5;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] det_x;
      logic signed [15:0] det_y;
      logic [15:0]        det_energy;
   } req_type;

   typedef struct packed {
      logic               target_valid;
      logic [7:0]         target_id;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic [15:0]        target_energy;
      logic [7:0]         target_age;
      logic [3:0]         target_missed;
      logic [3:0]         target_total;
      logic               list_end;
   } rsp_type;

endpackage

// File: rtl/gated_nearest_neighbor_tracker_top.sv
// Top level: greedy gated nearest-neighbor multi-target tracker.
//
//   port group | dir | meaning
//   req_*      | in  | one beat: detection, end of frame or clear
//   rsp_*      | out | one beat per listed target on end of frame, one if empty
//   csr_*      | in  | register write: gate, gain, missed limit
//
// A detection is scanned slot by slot by one shared squared-distance unit; on a match,
// one shared multiplier then smooths x and y, and an unmatched detection is buffered.
// End of frame runs miss update, backward delete scan, creation and listing, in that
// order, and listing waits while the output is stalled.
// Reset is synchronous; the block takes no beat while busy or while its
// output register holds a beat.
module gated_nearest_neighbor_tracker_top #(
   parameter int MAX_TARGETS = gnnt_pkg::MaxTargetsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gnnt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gnnt_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_data
);

   localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int CW = $clog2(MAX_TARGETS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_UPDX  = 4'd2;
   localparam logic [3:0] S_UPDY  = 4'd3;
   localparam logic [3:0] S_MISS  = 4'd4;
   localparam logic [3:0] S_DEL   = 4'd5;
   localparam logic [3:0] S_NEW   = 4'd6;
   localparam logic [3:0] S_LIST  = 4'd7;
   localparam logic [3:0] S_EMPTY = 4'd8;
   localparam logic [3:0] S_WRX   = 4'd9;

   // registers
   logic [14:0] gate_ff;
   logic [8:0]  gain_ff;
   logic [3:0]  limit_ff;

   logic signed [15:0] tx_ff [MAX_TARGETS];
   logic signed [15:0] ty_ff [MAX_TARGETS];
   logic [15:0] ten_ff [MAX_TARGETS];
   logic [7:0]  tid_ff [MAX_TARGETS];
   logic [7:0]  tage_ff [MAX_TARGETS];
   logic [3:0]  tmiss_ff [MAX_TARGETS];
   logic signed [15:0] px_ff [MAX_TARGETS];
   logic signed [15:0] py_ff [MAX_TARGETS];
   logic [15:0] pen_ff [MAX_TARGETS];

   logic [CW-1:0] count_ff;
   logic [CW-1:0] pcount_ff;
   logic [7:0]    nextid_ff;
   logic [MAX_TARGETS-1:0] mask_ff;

   logic [3:0]    state_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] best_idx_ff;
   logic          found_ff;
   logic [31:0]   best_ff;
   gnnt_pkg::req_type cur_ff;
   logic signed [15:0] sx_ff;
   logic          out_valid_ff;
   gnnt_pkg::rsp_type out_ff;

   assign req_stall = (state_ff != S_IDLE) || out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   wire req_acc = req_valid && !req_stall;
   wire out_free = !out_valid_ff || !rsp_stall;
   wire out_load = out_free && ((state_ff == S_LIST) || (state_ff == S_EMPTY));
   wire [IW-1:0] ix = idx_ff[IW-1:0];
   wire [IW-1:0] bx = best_idx_ff[IW-1:0];

   // shared squared-distance unit on magnitudes
   logic signed [16:0] ddx, ddy;
   logic [15:0] adx, ady;
   logic [33:0] sq_dist;
   always_comb begin
      ddx  = 17'(cur_ff.det_x) - 17'(tx_ff[ix]);
      ddy  = 17'(cur_ff.det_y) - 17'(ty_ff[ix]);
      adx  = ddx[16] ? 16'(-ddx) : ddx[15:0];
      ady  = ddy[16] ? 16'(-ddy) : ddy[15:0];
      sq_dist = 34'(32'(adx) * 32'(adx)) + 34'(32'(ady) * 32'(ady));
   end

   // shared smoothing multiplier: old*(256-g) + det*g, rounded
   logic [8:0] g;
   logic signed [15:0] s_old, s_det;
   logic signed [26:0] s_sum;
   logic signed [15:0] s_res;
   always_comb begin
      g     = (gain_ff > 9'd256) ? 9'd256 : gain_ff;
      s_old = (state_ff == S_UPDX) ? tx_ff[bx] : ty_ff[bx];
      s_det = (state_ff == S_UPDX) ? cur_ff.det_x : cur_ff.det_y;
      s_sum = 27'(s_old) * 27'(signed'({1'b0, 9'd256 - g}))
            + 27'(s_det) * 27'(signed'({1'b0, g})) + 27'sd128;
      s_res = s_sum[23:8];
   end

   wire [7:0] id_inc = nextid_ff + 8'd1;
   wire [7:0] id_next = (id_inc == 8'd0) ? 8'd1 : id_inc;
   wire [CW-1:0] last = count_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= gnnt_pkg::GATE_RESET;
         gain_ff <= gnnt_pkg::GAIN_RESET;
         limit_ff <= gnnt_pkg::LIMIT_RESET;
         count_ff <= '0;
         pcount_ff <= '0;
         nextid_ff <= 8'd1;
         mask_ff <= '0;
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_write) begin
            unique case (csr_index)
               gnnt_pkg::CSR_GATE:  gate_ff <= csr_data;
               gnnt_pkg::CSR_GAIN:  gain_ff <= csr_data[8:0];
               gnnt_pkg::CSR_LIMIT: limit_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (out_valid_ff && !rsp_stall && !out_load) out_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cur_ff <= req_data;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  best_ff <= 32'(gate_ff) * 32'(gate_ff);
                  unique case (req_data.opcode)
                     gnnt_pkg::OP_DETECT: state_ff <= S_SCAN;
                     gnnt_pkg::OP_FRAME:  state_ff <= S_MISS;
                     gnnt_pkg::OP_CLEAR: begin
                        count_ff <= '0;
                        pcount_ff <= '0;
                        mask_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            // one slot per cycle through the distance unit
            S_SCAN: begin
               if (idx_ff >= count_ff) begin
                  if (found_ff) state_ff <= S_UPDX;
                  else begin
                     if (pcount_ff < CW'(MAX_TARGETS)) begin
                        px_ff[pcount_ff[IW-1:0]] <= cur_ff.det_x;
                        py_ff[pcount_ff[IW-1:0]] <= cur_ff.det_y;
                        pen_ff[pcount_ff[IW-1:0]] <= cur_ff.det_energy;
                        pcount_ff <= pcount_ff + CW'(1);
                     end
                     state_ff <= S_IDLE;
                  end
               end else begin
                  if (!mask_ff[ix] && sq_dist < 34'(best_ff)) begin
                     best_ff <= sq_dist[31:0];
                     best_idx_ff <= idx_ff;
                     found_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_UPDX: begin
               sx_ff <= s_res;
               state_ff <= S_UPDY;
            end
            S_UPDY: begin
               ty_ff[bx] <= s_res;
               state_ff <= S_WRX;
            end
            S_WRX: begin
               tx_ff[bx] <= sx_ff;
               ten_ff[bx] <= cur_ff.det_energy;
               tmiss_ff[bx] <= 4'd0;
               if (tage_ff[bx] != 8'd255) tage_ff[bx] <= tage_ff[bx] + 8'd1;
               mask_ff[bx] <= 1'b1;
               state_ff <= S_IDLE;
            end
            // missed count on unmatched slots
            S_MISS: begin
               if (idx_ff >= count_ff) begin
                  idx_ff <= count_ff;
                  state_ff <= S_DEL;
               end else begin
                  if (!mask_ff[ix] && tmiss_ff[ix] != 4'd15)
                     tmiss_ff[ix] <= tmiss_ff[ix] + 4'd1;
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            // backward delete, hole filled from the end
            S_DEL: begin
               if (idx_ff == '0) begin
                  state_ff <= S_NEW;
               end else begin
                  if (tmiss_ff[IW'(idx_ff - CW'(1))] > limit_ff) begin
                     tx_ff[IW'(idx_ff - CW'(1))] <= tx_ff[last[IW-1:0]];
                     ty_ff[IW'(idx_ff - CW'(1))] <= ty_ff[last[IW-1:0]];
                     ten_ff[IW'(idx_ff - CW'(1))] <= ten_ff[last[IW-1:0]];
                     tid_ff[IW'(idx_ff - CW'(1))] <= tid_ff[last[IW-1:0]];
                     tage_ff[IW'(idx_ff - CW'(1))] <= tage_ff[last[IW-1:0]];
                     tmiss_ff[IW'(idx_ff - CW'(1))] <= tmiss_ff[last[IW-1:0]];
                     count_ff <= last;
                  end
                  idx_ff <= idx_ff - CW'(1);
               end
            end
            // create from buffer
            S_NEW: begin
               if (idx_ff >= pcount_ff || count_ff >= CW'(MAX_TARGETS)) begin
                  mask_ff <= '0;
                  pcount_ff <= '0;
                  idx_ff <= '0;
                  state_ff <= (count_ff == '0) ? S_EMPTY : S_LIST;
               end else begin
                  tx_ff[count_ff[IW-1:0]] <= px_ff[ix];
                  ty_ff[count_ff[IW-1:0]] <= py_ff[ix];
                  ten_ff[count_ff[IW-1:0]] <= pen_ff[ix];
                  tid_ff[count_ff[IW-1:0]] <= nextid_ff;
                  tage_ff[count_ff[IW-1:0]] <= 8'd1;
                  tmiss_ff[count_ff[IW-1:0]] <= 4'd0;
                  nextid_ff <= id_next;
                  count_ff <= count_ff + CW'(1);
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            // one result beat per slot
            S_LIST: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_ff.target_valid <= 1'b1;
                  out_ff.target_id <= tid_ff[ix];
                  out_ff.target_x <= tx_ff[ix];
                  out_ff.target_y <= ty_ff[ix];
                  out_ff.target_energy <= ten_ff[ix];
                  out_ff.target_age <= tage_ff[ix];
                  out_ff.target_missed <= tmiss_ff[ix];
                  out_ff.target_total <= 4'(count_ff);
                  out_ff.list_end <= (idx_ff == last);
                  idx_ff <= idx_ff + CW'(1);
                  if (idx_ff == last) state_ff <= S_IDLE;
               end
            end
            S_EMPTY: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_ff <= '{list_end: 1'b1, default: '0};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: sim/gnnt_checker.sv
// Checker: predicts the tracker's target lists and compares every result beat.
module gnnt_checker
   import gnnt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    csr_write,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data,
   output int      mismatches,
   output int      lists_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots = MaxTargetsDefault;

   // predicted registers
   logic [14:0] gate_q = GATE_RESET;
   logic [8:0]  gain_q = GAIN_RESET;
   logic [3:0]  limit_q = LIMIT_RESET;

   // predicted target list and detection buffer
   int          trk_x [Slots];
   int          trk_y [Slots];
   logic [15:0] trk_energy [Slots];
   logic [7:0]  trk_id [Slots];
   int          trk_age [Slots];
   int          trk_missed [Slots];
   int          trk_count = 0;
   logic [7:0]  id_next = 8'd1;
   logic [Slots-1:0] hit_mask = '0;
   int          buf_x [Slots];
   int          buf_y [Slots];
   logic [15:0] buf_energy [Slots];
   int          buf_count = 0;

   rsp_type     target_beats[$];

   initial mismatches = 0;
   assign lists_waiting = target_beats.size();

   task automatic report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // round-to-nearest exponential smoothing
   function automatic int ema(int old_pos, int det_pos);
      longint g, acc;
      g = (gain_q > 9'd256) ? 256 : longint'(gain_q);
      acc = longint'(old_pos) * (256 - g) + longint'(det_pos) * g;
      return int'((acc + 64'sd8388608 + 128) >>> 8) - 32768;
   endfunction

   task automatic copy_slot(int dst, int src);
      trk_x[dst] = trk_x[src];
      trk_y[dst] = trk_y[src];
      trk_energy[dst] = trk_energy[src];
      trk_id[dst] = trk_id[src];
      trk_age[dst] = trk_age[src];
      trk_missed[dst] = trk_missed[src];
   endtask

   task automatic track_beat(req_type r);
      int j, hit;
      longint best, d, ddx, ddy;
      rsp_type o;
      case (r.opcode)
         OP_DETECT: begin
            best = longint'(gate_q) * longint'(gate_q);
            hit = -1;
            for (j = 0; j < trk_count; j++) begin
               if (!hit_mask[j]) begin
                  ddx = longint'(r.det_x) - trk_x[j];
                  ddy = longint'(r.det_y) - trk_y[j];
                  d = ddx * ddx + ddy * ddy;
                  if (d < best) begin
                     best = d;
                     hit = j;
                  end
               end
            end
            if (hit >= 0) begin
               trk_x[hit] = ema(trk_x[hit], int'(r.det_x));
               trk_y[hit] = ema(trk_y[hit], int'(r.det_y));
               trk_energy[hit] = r.det_energy;
               trk_missed[hit] = 0;
               if (trk_age[hit] < 255) trk_age[hit]++;
               hit_mask[hit] = 1'b1;
            end else if (buf_count < Slots) begin
               buf_x[buf_count] = int'(r.det_x);
               buf_y[buf_count] = int'(r.det_y);
               buf_energy[buf_count] = r.det_energy;
               buf_count++;
            end
         end
         OP_CLEAR: begin
            trk_count = 0;
            hit_mask = '0;
            buf_count = 0;
         end
         OP_FRAME: begin
            // count a miss on unmatched targets
            for (j = 0; j < trk_count; j++)
               if (!hit_mask[j] && trk_missed[j] < 15) trk_missed[j]++;
            // backward delete, holes filled from the tail
            for (j = trk_count; j > 0; j--) begin
               if (trk_missed[j-1] > int'(limit_q)) begin
                  if (j - 1 < trk_count - 1) copy_slot(j - 1, trk_count - 1);
                  trk_count--;
               end
            end
            // births from buffered detections
            for (j = 0; j < buf_count && trk_count < Slots; j++) begin
               trk_id[trk_count] = id_next;
               id_next = (id_next == 8'd255) ? 8'd1 : id_next + 8'd1;
               trk_age[trk_count] = 1;
               trk_missed[trk_count] = 0;
               trk_x[trk_count] = buf_x[j];
               trk_y[trk_count] = buf_y[j];
               trk_energy[trk_count] = buf_energy[j];
               trk_count++;
            end
            hit_mask = '0;
            buf_count = 0;
            if (trk_count == 0) begin
               o = '0;
               o.list_end = 1'b1;
               target_beats.push_back(o);
            end
            for (j = 0; j < trk_count; j++) begin
               o.target_valid = 1'b1;
               o.target_id = trk_id[j];
               o.target_x = trk_x[j][15:0];
               o.target_y = trk_y[j][15:0];
               o.target_energy = trk_energy[j];
               o.target_age = trk_age[j][7:0];
               o.target_missed = trk_missed[j][3:0];
               o.target_total = trk_count[3:0];
               o.list_end = (j + 1 == trk_count);
               target_beats.push_back(o);
            end
         end
         default: ;
      endcase
   endtask

   task automatic field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_GATE:  gate_q = csr_data;
               CSR_GAIN:  gain_q = csr_data[8:0];
               CSR_LIMIT: limit_q = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (target_beats.size() == 0) begin
               report("result beat with no target expected");
            end else begin
               w = target_beats.pop_front();
               field("valid", rsp_data.target_valid, w.target_valid);
               field("id", rsp_data.target_id, w.target_id);
               field("x", rsp_data.target_x, w.target_x);
               field("y", rsp_data.target_y, w.target_y);
               field("energy", rsp_data.target_energy, w.target_energy);
               field("age", rsp_data.target_age, w.target_age);
               field("missed", rsp_data.target_missed, w.target_missed);
               field("total", rsp_data.target_total, w.target_total);
               field("list_end", rsp_data.list_end, w.list_end);
            end
         end
      end
   end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives detections, frame ends, clears and register writes into the tracker.
module tb_top;
   import gnnt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_GATE;
   logic [14:0] csr_data = '0;
   int          mismatches;
   int          lists_waiting;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          src_x [4];
   int          src_y [4];

   gated_nearest_neighbor_tracker_top u_top (.*);

   gnnt_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #3ms;
      $display("FAILURE");
      $finish;
   end

   // receiver stall, with long hold-offs repeated while requested
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) hold_left <= 400;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send(logic [1:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] e);
      req_type d;
      d.opcode = op;
      d.det_x = x;
      d.det_y = y;
      d.det_energy = e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // register writes only once every list has drained
   task automatic set_regs(logic [14:0] gate, logic [14:0] gain, logic [14:0] limit);
      req_valid <= 1'b0;
      @(posedge clock);
      while (lists_waiting != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_GATE;
      csr_data <= gate;
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_data <= gain;
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_data <= limit;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] near(int c);
      return 16'(c + $signed($urandom_range(600)) - 300);
   endfunction

   // frames of detections around a few moving sources, plus noise
   task automatic random_frames(int budget);
      int sent, n, k, s;
      sent = 0;
      while (sent < budget) begin
         for (s = 0; s < 4; s++) begin
            if ($urandom_range(9) == 0) begin
               src_x[s] = $signed($urandom_range(16000)) - 8000;
               src_y[s] = $signed($urandom_range(16000)) - 8000;
            end
         end
         n = $urandom_range(9);
         for (k = 0; k < n; k++) begin
            s = $urandom_range(3);
            if ($urandom_range(5) == 0)
               send(OP_DETECT, 16'($urandom), 16'($urandom), 16'($urandom));
            else
               send(OP_DETECT, near(src_x[s]), near(src_y[s]), 16'($urandom));
            sent++;
         end
         case ($urandom_range(29))
            0: send(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            1: send(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
            default: ;
         endcase
         send(OP_FRAME, 16'($urandom), 16'($urandom), 16'($urandom));
         sent++;
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < 4; k++) begin
         src_x[k] = k * 3000 - 4500;
         src_y[k] = 1000 - k * 700;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, extremes, ignored code, clear, full buffer
      send(OP_FRAME, 16'h0000, 16'h0000, 16'h0000);
      send(OP_DETECT, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send(OP_DETECT, 16'h8000, 16'h8000, 16'h0000);
      send(OP_DETECT, 16'h0000, 16'h0000, 16'h1234);
      send(OP_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(OP_DETECT, 16'h7FF0, 16'h7FF0, 16'hAAAA);
      send(OP_DETECT, 16'h0010, 16'hFFF0, 16'h5555);
      send(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(OP_FRAME, 16'h0000, 16'h0000, 16'h0000);
      for (k = 0; k < 10; k++) send(OP_DETECT, 16'(k * 4000), 16'(-k * 3000), 16'(k));
      send(OP_FRAME, 16'h0000, 16'h0000, 16'h0000);
      send(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(OP_FRAME, 16'h0000, 16'h0000, 16'h0000);

      // no idling, then long receiver hold-offs
      send_idle_pct = 0;
      stall_pct = 0;
      random_frames(20);
      hold_request = 1;
      random_frames(40);
      hold_request = 0;

      set_regs(15'd32767, 15'd256, 15'd0);
      send_idle_pct = 56;
      stall_pct = 0;
      random_frames(60);

      set_regs(15'd1, 15'd0, 15'd15);
      send_idle_pct = 0;
      stall_pct = 56;
      random_frames(30);
      for (k = 0; k < 6; k++) begin
         send(OP_DETECT, 16'h0100, 16'h0100, 16'(k));
         send(OP_FRAME, 16'h0000, 16'h0000, 16'h0000);
      end

      set_regs(15'd600, 15'd511, 15'd2);
      send_idle_pct = 8;
      stall_pct = 8;
      random_frames(60);

      req_valid <= 1'b0;
      @(posedge clock);
      while (lists_waiting != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && lists_waiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
